>>> sv/aes_pkg.sv
// aes-128 package: s-box, round constants and round functions
`default_nettype none

package aes_pkg;

   localparam int BLOCK_W = 128;
   localparam int KEY_W   = 64;
   localparam int ROUNDS  = 10;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   // index r gives the constant used to derive round key r
   localparam logic [7:0] RCON [11] = '{
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] GF_POLY = 8'h1b;

   typedef logic [BLOCK_W-1:0] block_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      logic [7:0] r;
      r = {a[6:0], 1'b0};
      if (a[7]) begin
         r = r ^ GF_POLY;
      end
      return r;
   endfunction

   // byte i of a block sits at bits 127-8i down
   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[s[BLOCK_W-1-8*((4*c+5*r) & 15) -: 8]];
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type t;
      logic [7:0] a0;
      logic [7:0] a1;
      logic [7:0] a2;
      logic [7:0] a3;
      logic [7:0] all;
      for (int c = 0; c < 4; c++) begin
         a0 = s[BLOCK_W-1-32*c -: 8];
         a1 = s[BLOCK_W-9-32*c -: 8];
         a2 = s[BLOCK_W-17-32*c -: 8];
         a3 = s[BLOCK_W-25-32*c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[BLOCK_W-1-32*c -: 8]  = a0 ^ all ^ xtime(a0 ^ a1);
         t[BLOCK_W-9-32*c -: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
         t[BLOCK_W-17-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[BLOCK_W-25-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   function automatic block_type next_round_key(input block_type rk, input logic [7:0] rcon);
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      t = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
      w0 = rk[127:96] ^ t;
      w1 = rk[95:64] ^ w0;
      w2 = rk[63:32] ^ w1;
      w3 = rk[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

`default_nettype wire

>>> sv/aes_stage.sv
// one cipher round stage with its round key derivation for the next stage
`default_nettype none

module aes_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire logic                  valid_i,
   input  wire aes_pkg::block_type    state_i,
   input  wire aes_pkg::block_type    rk_i,
   input  wire logic [7:0]            rcon_i,
   input  wire logic                  last_i,
   output logic                       valid_o,
   output aes_pkg::block_type         state_o,
   output aes_pkg::block_type         rk_o
);

   logic               valid_ff;
   aes_pkg::block_type state_ff;
   aes_pkg::block_type state_in;
   aes_pkg::block_type rk_ff;
   aes_pkg::block_type rk_in;
   aes_pkg::block_type subbed;

   always_comb begin
      subbed = aes_pkg::sub_shift(state_i);
      if (last_i) begin
         state_in = subbed ^ rk_i;
      end else begin
         state_in = aes_pkg::mix_columns(subbed) ^ rk_i;
      end
      rk_in = aes_pkg::next_round_key(rk_i, rcon_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff <= state_in;
         rk_ff    <= rk_in;
      end
   end

   assign valid_o = valid_ff;
   assign state_o = state_ff;
   assign rk_o    = rk_ff;

endmodule

`default_nettype wire

>>> sv/aes_skid.sv
// output skid stage between the round pipeline and the result channel
`default_nettype none

module aes_skid (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire aes_pkg::block_type    in_data,
   input  wire logic                  out_ready,
   output logic                       out_valid,
   output aes_pkg::block_type         out_data,
   output logic                       stall
);

   logic               skid_valid_ff;
   logic               skid_valid_in;
   aes_pkg::block_type skid_data_ff;

   always_comb begin
      if (skid_valid_ff) begin
         skid_valid_in = !out_ready;
      end else begin
         skid_valid_in = in_valid && !out_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = skid_valid_ff || in_valid;
   assign out_data  = skid_valid_ff ? skid_data_ff : in_data;
   assign stall     = skid_valid_ff;

endmodule

`default_nettype wire

>>> sv/aes128_block_encrypt.sv
// aes-128 block encryption top level: key registers, input stage, round pipeline
// an accepted block passes the input stage, then each round stage, to the skid stage
// throughput: one block per cycle while the skid stage is empty, set by the unrolled round pipeline
// round keys are derived stage by stage and travel with each block
// a refused result waits in the skid stage, which holds req_tready low until taken
// reset: synchronous, clears valid bits and both key registers to zero
`default_nettype none

module aes128_block_encrypt (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,   // plaintext_hi [63:0], plaintext_lo [127:64]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata,   // ciphertext_hi [63:0], ciphertext_lo [127:64]
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [3:0]    csr_paddr,
   input  wire logic [63:0]   csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);

   logic [aes_pkg::KEY_W-1:0] key_hi_ff;
   logic [aes_pkg::KEY_W-1:0] key_lo_ff;
   logic                      csr_write;

   logic                      pipe_en;
   logic                      stall;
   logic [aes_pkg::ROUNDS:0]  stage_valid;
   aes_pkg::block_type        stage_state [aes_pkg::ROUNDS+1];
   aes_pkg::block_type        stage_rk [aes_pkg::ROUNDS];

   logic                      valid0_ff;
   aes_pkg::block_type        state0_ff;
   aes_pkg::block_type        state0_in;
   aes_pkg::block_type        rk0_ff;
   aes_pkg::block_type        rk0_in;
   aes_pkg::block_type        key;
   aes_pkg::block_type        out_block;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[3] ? key_lo_ff : key_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[3]) begin
            key_lo_ff <= csr_pwdata;
         end else begin
            key_hi_ff <= csr_pwdata;
         end
      end
   end

   assign pipe_en    = !stall;
   assign req_tready = pipe_en;

   always_comb begin
      key       = {key_hi_ff, key_lo_ff};
      state0_in = {req_tdata[63:0], req_tdata[127:64]} ^ key;
      rk0_in    = aes_pkg::next_round_key(key, aes_pkg::RCON[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (pipe_en) begin
         valid0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         state0_ff <= state0_in;
         rk0_ff    <= rk0_in;
      end
   end

   assign stage_valid[0] = valid0_ff;
   assign stage_state[0] = state0_ff;
   assign stage_rk[0]    = rk0_ff;

   for (genvar i = 1; i <= aes_pkg::ROUNDS; i++) begin : g_round
      if (i < aes_pkg::ROUNDS) begin : g_mid
         aes_stage u_stage (
            .clock   (clock),
            .reset   (reset),
            .enable  (pipe_en),
            .valid_i (stage_valid[i-1]),
            .state_i (stage_state[i-1]),
            .rk_i    (stage_rk[i-1]),
            .rcon_i  (aes_pkg::RCON[i+1]),
            .last_i  (1'b0),
            .valid_o (stage_valid[i]),
            .state_o (stage_state[i]),
            .rk_o    (stage_rk[i])
         );
      end else begin : g_last
         aes_stage u_stage (
            .clock   (clock),
            .reset   (reset),
            .enable  (pipe_en),
            .valid_i (stage_valid[i-1]),
            .state_i (stage_state[i-1]),
            .rk_i    (stage_rk[i-1]),
            .rcon_i  (aes_pkg::RCON[0]),
            .last_i  (1'b1),
            .valid_o (stage_valid[i]),
            .state_o (stage_state[i]),
            .rk_o    ()
         );
      end
   end

   aes_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[aes_pkg::ROUNDS]),
      .in_data   (stage_state[aes_pkg::ROUNDS]),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_block),
      .stall     (stall)
   );

   assign rsp_tdata = {out_block[63:0], out_block[127:64]};

`ifndef NO_ASSERTIONS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> stage_valid[0])
      else $error("accepted block missing from input stage");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(stage_valid))
      else $error("pipeline moved while skid stage full");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(stall) |-> $past(stage_valid[aes_pkg::ROUNDS] && !rsp_tready))
      else $error("skid stage filled without a refused result");
`endif

endmodule

`default_nettype wire

>>> tb/aes128_block_encrypt_tb.sv
// testbench for the aes-128 block encryption core with its own cipher model
`timescale 1ns / 1ps

module aes128_block_encrypt_tb;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES = 10;
   localparam int BLOCKS_PER_PHASE = 140;
   localparam int MAX_PAUSE = 13;
   localparam int FLUSH_CYCLES = 24;
   localparam logic [7:0] GF_REDUCE = 8'h1b;
   localparam logic [7:0] AFFINE_CONST = 8'h63;
   localparam logic [7:0] RCON_FIRST = 8'h01;

   typedef enum logic [0:0] {
      REG_KEY_HI = 1'b0,
      REG_KEY_LO = 1'b1
   } key_reg_type;

   typedef enum int {
      PACE_STREAM = 0,
      PACE_RANDOM = 1,
      PACE_SPARSE = 2
   } pace_type;

   // hi sits in the low half, as on the stream data buses
   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
   } cipher_block_type;

   typedef struct packed {
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [63:0] pt_hi;
      logic [63:0] pt_lo;
      logic        typed;
      logic [63:0] ct_hi;
      logic [63:0] ct_lo;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 20;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{64'h0, 64'h0, '1, '1, 1'b0, 64'h0, 64'h0},
      '{64'h0, 64'h0, 64'h8000000000000000, 64'h0, 1'b0, 64'h0, 64'h0},
      '{64'h0, 64'h0, 64'h0, 64'h1, 1'b0, 64'h0, 64'h0},
      '{64'h0, 64'h0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0},
      '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0011223344556677,
        64'h8899aabbccddeeff, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
      '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h3243f6a8885a308d,
        64'h313198a2e0370734, 1'b1, 64'h3925841d02dc09fb, 64'hdc118597196a0b32},
      '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '1, '1, 1'b0, 64'h0, 64'h0},
      '{'1, '1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
      '{'1, '1, '1, '1, 1'b0, 64'h0, 64'h0},
      '{'1, '1, '1, '1, 1'b0, 64'h0, 64'h0},
      '{'1, 64'h0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'h0, 64'h0},
      '{64'h0, '1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0},
      '{64'h8000000000000000, 64'h1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
      '{64'h8000000000000000, 64'h1, '1, 64'h0, 1'b0, 64'h0, 64'h0},
      '{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{64'h0, 64'h0, 64'h00000000ffffffff, 64'hffffffff00000000, 1'b0, 64'h0, 64'h0},
      '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0011223344556677,
        64'h8899aabbccddeeff, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}
   };

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [127:0]  req_tdata;   // plaintext_hi [63:0], plaintext_lo [127:64]
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [127:0]  rsp_tdata;   // ciphertext_hi [63:0], ciphertext_lo [127:64]
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [3:0]    csr_paddr;
   logic [63:0]   csr_pwdata;
   logic [63:0]   csr_prdata;
   logic          csr_pready;

   logic [7:0]       sbox_tab [256];
   logic [63:0]      cur_key_hi;
   logic [63:0]      cur_key_lo;
   cipher_block_type pending_ciphertext [$];
   int               error_count;
   int               blocks_sent;
   int               checked_count;
   int               key_writes;
   int               cycle_count;

   aes128_block_encrypt u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
   endfunction

   function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = gf_double(x);
      end
      return acc;
   endfunction

   function automatic int pause_cycles(input pace_type pace);
      case (pace)
         PACE_STREAM: return 0;
         PACE_RANDOM: return $urandom_range(0, MAX_PAUSE);
         default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_PAUSE) : 0;
      endcase
   endfunction

   function automatic cipher_block_type aes128_encrypt(input logic [63:0] k_hi,
                                                       input logic [63:0] k_lo,
                                                       input cipher_block_type pt);
      logic [7:0]       rk [176];
      logic [7:0]       st [16];
      logic [7:0]       sh [16];
      logic [7:0]       t [4];
      logic [7:0]       rc;
      logic [7:0]       f;
      logic [7:0]       a0;
      logic [7:0]       a1;
      logic [7:0]       a2;
      logic [7:0]       a3;
      logic [7:0]       col_sum;
      cipher_block_type ct;
      rc = RCON_FIRST;
      for (int i = 0; i < 8; i++) begin
         rk[i]     = k_hi[63-8*i -: 8];
         rk[8+i]   = k_lo[63-8*i -: 8];
         st[i]     = pt.hi[63-8*i -: 8];
         st[8+i]   = pt.lo[63-8*i -: 8];
      end
      // key schedule, rotate and substitute on every fourth word
      for (int w = 4; w < 44; w++) begin
         for (int j = 0; j < 4; j++) begin
            t[j] = rk[4*(w-1)+j];
         end
         if (w % 4 == 0) begin
            f = t[0];
            t[0] = sbox_tab[t[1]] ^ rc;
            t[1] = sbox_tab[t[2]];
            t[2] = sbox_tab[t[3]];
            t[3] = sbox_tab[f];
            rc = gf_double(rc);
         end
         for (int j = 0; j < 4; j++) begin
            rk[4*w+j] = rk[4*(w-4)+j] ^ t[j];
         end
      end
      for (int i = 0; i < 16; i++) begin
         st[i] = st[i] ^ rk[i];
      end
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++) begin
            for (int b = 0; b < 4; b++) begin
               sh[4*c+b] = sbox_tab[st[(4*c+5*b) & 15]];
            end
         end
         for (int c = 0; c < 4; c++) begin
            a0 = sh[4*c];
            a1 = sh[4*c+1];
            a2 = sh[4*c+2];
            a3 = sh[4*c+3];
            if (r != 10) begin
               col_sum = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ col_sum ^ gf_double(a0 ^ a1);
               st[4*c+1] = a1 ^ col_sum ^ gf_double(a1 ^ a2);
               st[4*c+2] = a2 ^ col_sum ^ gf_double(a2 ^ a3);
               st[4*c+3] = a3 ^ col_sum ^ gf_double(a3 ^ a0);
            end else begin
               st[4*c]   = a0;
               st[4*c+1] = a1;
               st[4*c+2] = a2;
               st[4*c+3] = a3;
            end
         end
         for (int i = 0; i < 16; i++) begin
            st[i] = st[i] ^ rk[16*r+i];
         end
      end
      for (int i = 0; i < 8; i++) begin
         ct.hi[63-8*i -: 8] = st[i];
         ct.lo[63-8*i -: 8] = st[8+i];
      end
      return ct;
   endfunction

   task automatic csr_access(input key_reg_type idx, input bit is_write,
                             input logic [63:0] wdata, output logic [63:0] rdata);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = is_write;
      csr_paddr   = {idx, 3'b000};
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic check_key(input key_reg_type idx);
      logic [63:0] got;
      logic [63:0] want;
      want = (idx == REG_KEY_HI) ? cur_key_hi : cur_key_lo;
      csr_access(idx, 1'b0, 64'h0, got);
      if (got !== want) begin
         $error("%s readback mismatch: expected %h, got %h", idx.name(), want, got);
         error_count++;
      end
   endtask

   task automatic write_key(input key_reg_type idx, input logic [63:0] value);
      logic [63:0] unused;
      csr_access(idx, 1'b1, value, unused);
      if (idx == REG_KEY_HI) begin
         cur_key_hi = value;
      end else begin
         cur_key_lo = value;
      end
      key_writes++;
      check_key(idx);
   endtask

   task automatic send_block(input cipher_block_type pt, input bit typed,
                             input cipher_block_type typed_ct, input int gap);
      cipher_block_type expected;
      expected = typed ? typed_ct : aes128_encrypt(cur_key_hi, cur_key_lo, pt);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = pt;
      do @(posedge clock); while (!req_tready);
      pending_ciphertext.push_back(expected);
      blocks_sent++;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata  = {$urandom, $urandom, $urandom, $urandom};
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_ciphertext.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL aes128_block_encrypt");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      cipher_block_type got;
      cipher_block_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_ciphertext.size() == 0) begin
            $error("unexpected ciphertext transfer: %h", got);
            error_count++;
         end else begin
            want = pending_ciphertext.pop_front();
            checked_count++;
            if (got.hi !== want.hi) begin
               $error("ciphertext_hi mismatch: expected %h, got %h", want.hi, got.hi);
               error_count++;
            end
            if (got.lo !== want.lo) begin
               $error("ciphertext_lo mismatch: expected %h, got %h", want.lo, got.lo);
               error_count++;
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      pace_type rx_pace;
      int       stall;
      int       taken;
      rsp_tready = 1'b0;
      rx_pace = PACE_RANDOM;
      taken = 0;
      while (reset !== 1'b0) begin
         @(negedge clock);
      end
      forever begin
         if (taken % 64 == 0) begin
            rx_pace = pace_type'($urandom_range(0, 2));
         end
         stall = pause_cycles(rx_pace);
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin
      directed_row_type row;
      cipher_block_type pt;
      cipher_block_type prev_pt;
      cipher_block_type typed_ct;
      logic [7:0]       inv;
      logic [7:0]       p;
      logic [63:0]      new_hi;
      logic [63:0]      new_lo;
      pace_type         tx_pace;
      int               kind;
      int               which;
      int               pos;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cur_key_hi  = '0;
      cur_key_lo  = '0;
      error_count = 0;
      blocks_sent = 0;
      checked_count = 0;
      key_writes  = 0;
      cycle_count = 0;

      // s-box from the field inverse (a^254) and the affine map
      for (int v = 0; v < 256; v++) begin
         inv = 8'h01;
         p = v[7:0];
         for (int e = 0; e < 8; e++) begin
            if (e != 0) begin
               inv = gf_product(inv, p);
            end
            p = gf_product(p, p);
         end
         sbox_tab[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                       ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_CONST;
      end

      repeat (9) @(negedge clock);
      reset = 1'b0;

      check_key(REG_KEY_HI);
      check_key(REG_KEY_LO);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.key_hi != cur_key_hi || row.key_lo != cur_key_lo) begin
            drain_results();
            if (row.key_hi != cur_key_hi) begin
               write_key(REG_KEY_HI, row.key_hi);
            end
            if (row.key_lo != cur_key_lo) begin
               write_key(REG_KEY_LO, row.key_lo);
            end
         end
         pt.hi = row.pt_hi;
         pt.lo = row.pt_lo;
         typed_ct.hi = row.ct_hi;
         typed_ct.lo = row.ct_lo;
         send_block(pt, row.typed, typed_ct, pause_cycles(i < 10 ? PACE_STREAM : PACE_RANDOM));
      end

      prev_pt = pt;
      for (int phase = 0; phase < PHASES; phase++) begin
         // every key change waits for the pipeline to empty
         drain_results();
         kind = $urandom_range(0, 5);
         case (kind)
            0: begin
               new_hi = '0;
               new_lo = '0;
            end
            1: begin
               new_hi = '1;
               new_lo = '1;
            end
            2: begin
               new_hi = '0;
               new_lo = '0;
               pos = $urandom_range(0, 127);
               if (pos < 64) begin
                  new_hi[pos] = 1'b1;
               end else begin
                  new_lo[pos-64] = 1'b1;
               end
            end
            default: begin
               new_hi = {$urandom, $urandom};
               new_lo = {$urandom, $urandom};
            end
         endcase
         which = $urandom_range(0, 2);
         if (which != 1) begin
            write_key(REG_KEY_HI, new_hi);
         end
         if (which != 0) begin
            write_key(REG_KEY_LO, new_lo);
         end
         tx_pace = pace_type'(phase % 3);
         for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
            kind = $urandom_range(0, 9);
            case (kind)
               0: pt = '0;
               1: pt = '1;
               2: begin
                  pt = '0;
                  pt[$urandom_range(0, 127)] = 1'b1;
               end
               3: pt = prev_pt;
               4: begin
                  pt = prev_pt;
                  pos = $urandom_range(0, 127);
                  pt[pos] = ~pt[pos];
               end
               default: pt = {$urandom, $urandom, $urandom, $urandom};
            endcase
            send_block(pt, 1'b0, '0, pause_cycles(tx_pace));
            prev_pt = pt;
         end
      end

      drain_results();
      repeat (FLUSH_CYCLES) @(posedge clock);

      $display("%0d blocks sent, %0d ciphertexts checked against the cipher model",
               blocks_sent, checked_count);
      $display("%0d key register writes with read-back over %0d key phases",
               key_writes, PHASES);
      if (error_count == 0) begin
         $display("PASS aes128_block_encrypt");
      end else begin
         $display("FAIL aes128_block_encrypt");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/aes_pkg.sv
sv/aes_stage.sv
sv/aes_skid.sv
sv/aes128_block_encrypt.sv
tb/aes128_block_encrypt_tb.sv
